[hw/rtl/lfpr_pkg.sv]
`default_nettype none

package lfpr_pkg;

  // Payload store of one frame.
  localparam int STORE_DEPTH = 16;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int LEN_W       = $clog2(STORE_DEPTH + 1);
  localparam int CNT_W       = 5;

  localparam int CFG_IDX_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_VALUE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT   = 8'd1;

  localparam logic [7:0] HEADER_RESET     = 8'h11;
  localparam logic [7:0] IDLE_LIMIT_RESET = 8'd100;

  // Input word kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FETCH,
    ST_LOAD
  } lfpr_state_t;

  typedef struct packed {
    logic take;
    logic load_err;
    logic emit_clear;
    logic emit_load;
  } lfpr_cmd_t;

  typedef struct packed {
    logic close_good;
    logic close_bad;
    logic emit_last;
    logic out_free;
  } lfpr_sts_t;

endpackage

`default_nettype wire

[hw/rtl/lfpr_dp.sv]
`default_nettype none

module lfpr_dp
  import lfpr_pkg::*;
#(
  parameter int MAX_FRAME_LEN = 20
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lfpr_cmd_t            cmd,
  output lfpr_sts_t                 sts,
  input  wire logic                 in_kind,
  input  wire logic [7:0]           in_byte,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  input  wire logic                 out_tready,
  output logic                      out_valid,
  output logic                      out_status,
  output logic [7:0]                out_byte,
  output logic                      out_last
);

  localparam logic [8:0] MaxLen = 9'(MAX_FRAME_LEN);

  logic [7:0]          header_r;
  logic [7:0]          idle_limit_r;
  logic [7:0]          idle_count_r, idle_count_nxt;
  logic [CNT_W-1:0]    byte_count_r, byte_count_nxt;
  logic [LEN_W-1:0]    decl_len_r, decl_len_nxt;
  logic [7:0]          sum_r, sum_nxt;
  logic [7:0]          mem [STORE_DEPTH];
  logic [7:0]          rd_data_r;
  logic [STORE_AW-1:0] emit_idx_r;
  logic                out_valid_r;
  logic                out_status_r;
  logic [7:0]          out_byte_r;
  logic                out_last_r;

  logic                idle_expired;
  logic [CNT_W-1:0]    bc_eff;
  logic [CNT_W-1:0]    pos;
  logic                len_ok;
  logic                wr_en;
  logic                close_good, close_bad;

  always_comb begin
    idle_expired   = idle_count_r >= idle_limit_r;
    bc_eff         = idle_expired ? '0 : byte_count_r;
    pos            = bc_eff - CNT_W'(2);
    len_ok         = (({1'b0, in_byte} + 9'd3) < MaxLen) && (in_byte <= 8'(STORE_DEPTH));
    idle_count_nxt = idle_expired ? idle_count_r : idle_count_r + 8'd1;
    byte_count_nxt = bc_eff;
    decl_len_nxt   = decl_len_r;
    sum_nxt        = sum_r;
    wr_en          = 1'b0;
    close_good     = 1'b0;
    close_bad      = 1'b0;
    if (in_kind == KIND_BYTE) begin
      idle_count_nxt = '0;
      if (bc_eff == CNT_W'(0)) begin
        if (in_byte == header_r) begin
          sum_nxt        = in_byte;
          byte_count_nxt = CNT_W'(1);
        end
      end else if (bc_eff == CNT_W'(1)) begin
        if (!len_ok) begin
          byte_count_nxt = '0;
        end else begin
          decl_len_nxt   = in_byte[LEN_W-1:0];
          sum_nxt        = sum_r + in_byte;
          byte_count_nxt = CNT_W'(2);
        end
      end else if (pos < CNT_W'(decl_len_r)) begin
        wr_en          = 1'b1;
        sum_nxt        = sum_r + in_byte;
        byte_count_nxt = bc_eff + CNT_W'(1);
      end else begin
        // Checksum word closes the frame; an empty frame is never checked.
        byte_count_nxt = '0;
        if (decl_len_r != '0) begin
          close_good = (in_byte == sum_r);
          close_bad  = (in_byte != sum_r);
        end
      end
    end
  end

  always_comb begin
    sts.close_good = close_good;
    sts.close_bad  = close_bad;
    sts.emit_last  = (LEN_W'(emit_idx_r) + LEN_W'(1)) == decl_len_r;
    sts.out_free   = !out_valid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r     <= HEADER_RESET;
      idle_limit_r <= IDLE_LIMIT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_HEADER_VALUE) begin
        header_r <= cfg_data;
      end else if (cfg_index == CFG_IDLE_LIMIT) begin
        idle_limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_count_r <= '0;
      byte_count_r <= '0;
      decl_len_r   <= '0;
      sum_r        <= '0;
    end else if (cmd.take) begin
      idle_count_r <= idle_count_nxt;
      byte_count_r <= byte_count_nxt;
      decl_len_r   <= decl_len_nxt;
      sum_r        <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && wr_en) begin
      mem[pos[STORE_AW-1:0]] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[emit_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_idx_r <= '0;
    end else if (cmd.emit_clear) begin
      emit_idx_r <= '0;
    end else if (cmd.emit_load) begin
      emit_idx_r <= emit_idx_r + STORE_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_err || cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_err) begin
      out_status_r <= STATUS_ERR;
      out_byte_r   <= '0;
      out_last_r   <= 1'b1;
    end else if (cmd.emit_load) begin
      out_status_r <= STATUS_OK;
      out_byte_r   <= rd_data_r;
      out_last_r   <= sts.emit_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;

  // A result must never overwrite one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_err || cmd.emit_load) |-> (!out_valid_r || out_tready))
    else $error("result register overwritten while still pending");

  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load_err && cmd.emit_load))
    else $error("error and payload results loaded together");

  a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(cmd.take) && $past(rst_n) |-> $stable(sum_r) && $stable(byte_count_r))
    else $error("frame state changed without an accepted word");

endmodule

`default_nettype wire

[hw/rtl/lfpr_ctrl.sv]
`default_nettype none

module lfpr_ctrl
  import lfpr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire lfpr_sts_t sts,
  output lfpr_cmd_t      cmd
);

  lfpr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    in_tready      = 1'b0;
    cmd.take       = 1'b0;
    cmd.load_err   = 1'b0;
    cmd.emit_clear = 1'b0;
    cmd.emit_load  = 1'b0;
    case (state_r)
      ST_RUN: begin
        in_tready    = sts.out_free;
        cmd.take     = in_tvalid && sts.out_free;
        cmd.load_err = cmd.take && sts.close_bad;
        if (cmd.take && sts.close_good) begin
          cmd.emit_clear = 1'b1;
          state_nxt      = ST_FETCH;
        end
      end
      // The store read address settles here; the data is registered for ST_LOAD.
      ST_FETCH: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          state_nxt     = sts.emit_last ? ST_RUN : ST_FETCH;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  a_no_take_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RUN) |-> !in_tready)
    else $error("input accepted during payload burst");

  a_burst_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && sts.close_good) |=> (state_r == ST_FETCH))
    else $error("good frame did not start a payload burst");

  a_fetch_then_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH) |=> (state_r == ST_LOAD))
    else $error("store fetch not followed by load");

endmodule

`default_nettype wire

[hw/rtl/length_framed_packet_receiver_core.sv]
`default_nettype none

// Receiver for length-prefixed serial frames: header byte, length byte L, L payload
// bytes and an 8-bit additive checksum of all preceding bytes. Each input word is a
// received byte or an idle tick (tuser high); a partial frame is dropped once
// idle_limit ticks pass without a byte, and lengths that do not fit the 16-byte store
// or MAX_FRAME_LEN abort the frame. While receiving, one input word is taken per
// cycle while the result register is free. A good frame with L > 0 is then sent
// as L payload words, tlast on the final one, each paced by the registered read
// of the payload store (address step, then load of the output register once it
// is free); no input is taken during that burst. A checksum mismatch gives one
// word with tuser high, data zero and tlast high. Configuration writes are always
// ready; index 0 is the header value (reset 0x11), index 1 the idle limit (reset 100).
module length_framed_packet_receiver_core
  import lfpr_pkg::*;
#(
  parameter int MAX_FRAME_LEN = 20
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [7:0]           in_tdata,   // [7:0] rx_byte
  input  wire logic                 in_tuser,   // [0] kind: 0 byte, 1 idle tick
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [7:0]                out_tdata,  // [7:0] payload_byte
  output logic                      out_tuser,  // [0] status: 0 payload, 1 checksum error
  output logic                      out_tlast,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  lfpr_cmd_t cmd;
  lfpr_sts_t sts;

  assign cfg_ready = 1'b1;

  lfpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lfpr_dp #(
    .MAX_FRAME_LEN (MAX_FRAME_LEN)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_kind    (in_tuser),
    .in_byte    (in_tdata),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_status (out_tuser),
    .out_byte   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

`default_nettype wire

[tb/lfpr_payload_monitor.sv]
`default_nettype none

// Watches the input, configuration and result channels of the frame receiver. It keeps
// its own copy of the frame state, queues the result words that each frame should
// produce, and compares every result word taken from the block against them.
module lfpr_payload_monitor
  import lfpr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  input  wire logic                 in_tready,
  input  wire logic [7:0]           in_tdata,
  input  wire logic                 in_tuser,
  input  wire logic                 out_tvalid,
  input  wire logic                 out_tready,
  input  wire logic [7:0]           out_tdata,
  input  wire logic                 out_tuser,
  input  wire logic                 out_tlast,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  output int                        mismatch_count,
  output int                        words_owed
);

  localparam int MAX_FRAME_LEN = 20;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic       status;
    logic [7:0] payload_byte;
    logic       last;
  } result_word_t;

  result_word_t     owed_results[$];
  logic [7:0]       header_value;
  logic [7:0]       idle_limit;
  logic [7:0]       frame_bytes [STORE_DEPTH];
  logic [CNT_W-1:0] byte_count;
  logic [CNT_W-1:0] declared_len;
  logic [7:0]       running_sum;
  logic [7:0]       idle_count;

  // Advances the frame state by one input word and queues any payload it releases.
  task automatic absorb_word(input logic kind, input logic [7:0] b);
    result_word_t w;
    int           pos;
    int           i;
    if (idle_count < idle_limit) begin
      idle_count = idle_count + 8'd1;
    end else begin
      byte_count = '0;
    end
    if (kind == KIND_BYTE) begin
      idle_count = '0;
      pos = int'(byte_count) - 2;
      if (byte_count == 0) begin
        if (b == header_value) begin
          running_sum = b;
          byte_count  = CNT_W'(1);
        end
      end else if (byte_count == 1) begin
        if (int'(b) + 3 >= MAX_FRAME_LEN || int'(b) > STORE_DEPTH) begin
          byte_count = '0;
        end else begin
          declared_len = b[CNT_W-1:0];
          running_sum  = running_sum + b;
          byte_count   = CNT_W'(2);
        end
      end else if (pos < int'(declared_len)) begin
        frame_bytes[pos % STORE_DEPTH] = b;
        running_sum = running_sum + b;
        byte_count  = byte_count + CNT_W'(1);
      end else begin
        // Checksum byte closes the frame; an empty payload is never checked.
        byte_count = '0;
        if (declared_len != 0) begin
          if (b != running_sum) begin
            w.status       = STATUS_ERR;
            w.payload_byte = '0;
            w.last         = 1'b1;
            owed_results.push_back(w);
          end else begin
            for (i = 0; i < int'(declared_len); i++) begin
              w.status       = STATUS_OK;
              w.payload_byte = frame_bytes[i];
              w.last         = (i + 1 == int'(declared_len));
              owed_results.push_back(w);
            end
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    result_word_t w;
    if (!rst_n) begin
      header_value   = HEADER_RESET;
      idle_limit     = IDLE_LIMIT_RESET;
      byte_count     = '0;
      declared_len   = '0;
      running_sum    = '0;
      idle_count     = '0;
      mismatch_count = 0;
      owed_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (owed_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("unexpected result word: status %0d byte %02h last %0d",
                     out_tuser, out_tdata, out_tlast);
          end
        end else begin
          w = owed_results.pop_front();
          if (w.status !== out_tuser || w.payload_byte !== out_tdata ||
              w.last !== out_tlast) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("result mismatch: expected status %0d byte %02h last %0d, got %0d %02h %0d",
                       w.status, w.payload_byte, w.last, out_tuser, out_tdata, out_tlast);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_HEADER_VALUE) begin
          header_value = cfg_data;
        end else if (cfg_index == CFG_IDLE_LIMIT) begin
          idle_limit = cfg_data;
        end
      end
      if (in_tvalid && in_tready) begin
        absorb_word(in_tuser, in_tdata);
      end
    end
    words_owed = owed_results.size();
  end

endmodule

`default_nettype wire

[tb/tb_length_framed_packet_receiver_core.sv]
`default_nettype none

module tb_length_framed_packet_receiver_core;
  import lfpr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 40;
  localparam int PHASE_WORDS = 8;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = '0;
  logic                 in_tuser   = KIND_BYTE;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;
  logic                 out_tuser;
  logic                 out_tlast;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [7:0]           cfg_data   = '0;

  int         mismatch_count;
  int         words_owed;
  int         cycle_count = 0;
  int         words_sent  = 0;
  logic       calm        = 1'b0;
  logic [7:0] hdr_now;
  logic [7:0] limit_now;

  length_framed_packet_receiver_core dut (.*);

  lfpr_payload_monitor monitor (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= 34);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_length_framed_packet_receiver_core: done, errors");
      $finish;
    end
  end

  // All tasks start and end at a falling edge.
  task automatic put_word(input logic kind, input logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < 34) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = b;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic put_tick();
    put_word(KIND_TICK, 8'($urandom));
  endtask

  task automatic maybe_ticks(input int tick_max);
    if (tick_max > 0 && $urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, tick_max)) put_tick();
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == CFG_HEADER_VALUE) begin
      hdr_now = val;
    end else if (idx == CFG_IDLE_LIMIT) begin
      limit_now = val;
    end
  endtask

  // Waits until every owed result has come out and the emit burst has wound down.
  task automatic settle();
    in_tvalid = 1'b0;
    while (words_owed != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input logic [7:0] header, input logic [7:0] limit);
    settle();
    write_reg(CFG_HEADER_VALUE, header);
    write_reg(CFG_IDLE_LIMIT, limit);
    // Writes to an unmapped index must leave both registers alone.
    write_reg(CFG_IDX_W'($urandom_range(2, 255)), 8'($urandom));
  endtask

  // A fill below zero gives random payload bytes.
  task automatic send_frame(input logic [7:0] len, input logic [7:0] sum_flip,
                            input int fill, input int tick_max);
    logic [7:0] sum;
    logic [7:0] b;
    int         i;
    sum = hdr_now + len;
    put_word(KIND_BYTE, hdr_now);
    maybe_ticks(tick_max);
    put_word(KIND_BYTE, len);
    for (i = 0; i < int'(len); i++) begin
      maybe_ticks(tick_max);
      b   = (fill < 0) ? 8'($urandom) : 8'(fill);
      sum = sum + b;
      put_word(KIND_BYTE, b);
    end
    maybe_ticks(tick_max);
    put_word(KIND_BYTE, sum ^ sum_flip);
  endtask

  // Two-byte frame with a run of ticks in its middle; it survives only if the run
  // is shorter than the idle limit.
  task automatic tick_frame(input int run);
    logic [7:0] b0;
    logic [7:0] b1;
    b0 = 8'($urandom);
    b1 = 8'($urandom);
    put_word(KIND_BYTE, hdr_now);
    put_word(KIND_BYTE, 8'd2);
    put_word(KIND_BYTE, b0);
    repeat (run) put_tick();
    put_word(KIND_BYTE, b1);
    put_word(KIND_BYTE, hdr_now + 8'd2 + b0 + b1);
  endtask

  task automatic random_burst();
    int         r;
    int         p;
    logic [7:0] len;
    logic [7:0] flip;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      p   = $urandom_range(0, 9);
      len = (p == 0) ? 8'd16 : (p == 1) ? 8'd0 : 8'($urandom_range(1, 8));
      flip = ($urandom_range(0, 99) < 15) ? 8'($urandom_range(1, 255)) : 8'd0;
      send_frame(len, flip, -1, (limit_now <= 8) ? int'(limit_now) + 1 : 4);
    end else if (r < 85) begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 1) == 0) begin
          put_tick();
        end else begin
          put_word(KIND_BYTE, 8'($urandom));
        end
      end
    end else begin
      // Header and length, then the frame is cut short.
      put_word(KIND_BYTE, hdr_now);
      put_word(KIND_BYTE, ($urandom_range(0, 1) == 0) ? 8'($urandom_range(17, 255))
                                                      : 8'($urandom_range(1, 16)));
      repeat ($urandom_range(0, 3)) put_word(KIND_BYTE, 8'($urandom));
    end
  endtask

  task automatic run_phase();
    words_sent = 0;
    while (words_sent < PHASE_WORDS) random_burst();
  endtask

  initial begin
    hdr_now   = HEADER_RESET;
    limit_now = IDLE_LIMIT_RESET;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Bytes that do not open a frame.
    put_word(KIND_BYTE, 8'h00);
    put_word(KIND_BYTE, 8'hFF);
    // Empty payload with a wrong checksum gives nothing.
    send_frame(8'd0, 8'h5A, -1, 0);
    // Lengths past the store abort the frame.
    put_word(KIND_BYTE, hdr_now);
    put_word(KIND_BYTE, 8'd17);
    put_word(KIND_BYTE, hdr_now);
    put_word(KIND_BYTE, 8'hFF);
    // One-byte frame with an idle tick inside.
    put_word(KIND_BYTE, hdr_now);
    put_word(KIND_BYTE, 8'd1);
    put_tick();
    put_word(KIND_BYTE, 8'hFF);
    put_word(KIND_BYTE, hdr_now + 8'd1 + 8'hFF);
    send_frame(8'd2, 8'h80, 8'h00, 0);
    send_frame(8'd3, 8'h00, -1, 0);
    run_phase();

    configure(8'h00, 8'd1);
    tick_frame(0);
    tick_frame(1);
    run_phase();

    calm = 1'b1;
    configure(8'hFF, 8'd255);
    send_frame(8'd16, 8'h00, 8'hFF, 0);
    run_phase();
    calm = 1'b0;

    configure(8'($urandom), 8'($urandom_range(2, 8)));
    run_phase();

    configure(HEADER_RESET, 8'd3);
    run_phase();

    settle();
    if (mismatch_count == 0) begin
      $display("tb_length_framed_packet_receiver_core: done, clean");
    end else begin
      $display("tb_length_framed_packet_receiver_core: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
